[rtl/core/srle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srle_pkg;

    localparam int SIZE_CODE_W = 3;
    localparam logic [SIZE_CODE_W-1:0] SIZE_CODE_RESET = 3'd2;
    localparam logic [15:0] LIMIT_BASE = 16'd128;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN_TYPE = 2'd1;
    localparam logic [1:0] ERR_PATTERN_LONG = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW    = 2'd3;

    localparam logic [7:0] TYPE_COPY    = 8'd0;
    localparam logic [7:0] TYPE_PAIR    = 8'd1;
    localparam logic [7:0] TYPE_BLOCKS  = 8'd2;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] in_byte;
    } t_in_word;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        byte_taken;
        logic        record_done;
        logic [15:0] decoded_length;
        logic [1:0]  error_code;
    } t_out_word;

endpackage

`default_nettype wire

[rtl/core/srle_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none

module srle_decoder #(
    parameter int PATTERN_LOG_MAX = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire srle_pkg::t_in_word            i_item,
    input  wire logic [srle_pkg::SIZE_CODE_W-1:0] i_size_code,
    output srle_pkg::t_out_word                o_result
);

    localparam int ADDR_W = PATTERN_LOG_MAX;
    localparam int DEPTH  = 1 << PATTERN_LOG_MAX;
    localparam int IDX_W  = PATTERN_LOG_MAX + 1;
    localparam int PL_W   = $clog2(PATTERN_LOG_MAX + 1);

    typedef enum logic [3:0] {
        PH_LEN_LO  = 4'd0,
        PH_LEN_HI  = 4'd1,
        PH_TYPE    = 4'd2,
        PH_COPY    = 4'd3,
        PH_T1_CLO  = 4'd4,
        PH_T1_CHI  = 4'd5,
        PH_T1_D1   = 4'd6,
        PH_T1_D2   = 4'd7,
        PH_REPLAY1 = 4'd8,
        PH_DISCARD = 4'd9,
        PH_BLK_HDR = 4'd10,
        PH_BLK_CNT = 4'd11,
        PH_LIT     = 4'd12,
        PH_FILL    = 4'd13,
        PH_REPLAY2 = 4'd14
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [15:0]       r_payload, n_payload;
    logic [15:0]       r_run, n_run;
    logic [PL_W-1:0]   r_log, n_log;
    logic [IDX_W-1:0]  r_fill, n_fill;
    logic [IDX_W-1:0]  r_replay, n_replay;
    logic [15:0]       r_count, n_count;
    logic [1:0]        r_err, n_err;

    logic [7:0]        r_store [DEPTH];
    logic [7:0]        r_rd_data;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic [IDX_W-1:0]  pat_len;
    logic [15:0]       limit;
    logic [7:0]        b;
    logic              do_emit;
    logic [7:0]        emit_data;
    logic              raise_en;
    logic [1:0]        raise_code;
    logic              end_req;
    t_phase            end_next;
    logic              taken;
    logic              done;
    logic              out_ok;
    logic [7:0]        out_data;

    assign pat_len   = IDX_W'(1) << r_log;
    assign limit     = srle_pkg::LIMIT_BASE << i_size_code;
    assign b         = i_item.in_byte;
    assign mem_raddr = n_replay[ADDR_W-1:0];

    always_comb begin
        n_phase    = r_phase;
        n_payload  = r_payload;
        n_run      = r_run;
        n_log      = r_log;
        n_fill     = r_fill;
        n_replay   = r_replay;
        n_count    = r_count;
        n_err      = r_err;
        mem_we     = 1'b0;
        mem_waddr  = r_fill[ADDR_W-1:0];
        mem_wdata  = b;
        do_emit    = 1'b0;
        emit_data  = b;
        raise_en   = 1'b0;
        raise_code = srle_pkg::ERR_NONE;
        end_req    = 1'b0;
        end_next   = PH_LEN_LO;
        taken      = 1'b0;
        done       = 1'b0;
        out_ok     = 1'b0;
        out_data   = 8'd0;

        if (r_phase == PH_REPLAY1 || r_phase == PH_REPLAY2) begin
            do_emit   = 1'b1;
            emit_data = r_rd_data;
            n_replay  = r_replay + IDX_W'(1);
            if (n_replay >= pat_len) begin
                n_replay = '0;
                n_run    = r_run - 16'd1;
                if (n_run == 16'd0) begin
                    end_req  = 1'b1;
                    end_next = (r_phase == PH_REPLAY1) ? PH_DISCARD : PH_BLK_HDR;
                end
            end
        end else if (i_item.has_byte) begin
            taken = 1'b1;
            if (r_phase >= PH_COPY && r_payload != 16'd0) begin
                n_payload = r_payload - 16'd1;
            end
            case (r_phase)
                PH_LEN_LO: begin
                    n_payload = {8'd0, b};
                    n_count   = 16'd0;
                    n_err     = srle_pkg::ERR_NONE;
                    n_phase   = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_payload = {b, r_payload[7:0]};
                    if (n_payload != 16'd0) begin
                        n_payload = n_payload - 16'd1;
                    end
                    n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    end_req = 1'b1;
                    if (b == srle_pkg::TYPE_COPY) begin
                        end_next = PH_COPY;
                    end else if (b == srle_pkg::TYPE_PAIR) begin
                        end_next = PH_T1_CLO;
                    end else if (b == srle_pkg::TYPE_BLOCKS) begin
                        end_next = PH_BLK_HDR;
                    end else begin
                        raise_en   = 1'b1;
                        raise_code = srle_pkg::ERR_UNKNOWN_TYPE;
                        end_next   = PH_DISCARD;
                    end
                end
                PH_COPY: begin
                    do_emit  = 1'b1;
                    end_req  = 1'b1;
                    end_next = PH_COPY;
                end
                PH_T1_CLO: begin
                    n_run    = {8'd0, b};
                    end_req  = 1'b1;
                    end_next = PH_T1_CHI;
                end
                PH_T1_CHI: begin
                    n_run    = {b, r_run[7:0]};
                    end_req  = 1'b1;
                    end_next = PH_T1_D1;
                end
                PH_T1_D1: begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(0);
                    end_req   = 1'b1;
                    end_next  = PH_T1_D2;
                end
                PH_T1_D2: begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(1);
                    n_log     = PL_W'(1);
                    n_replay  = '0;
                    if (r_run != 16'd0) begin
                        n_phase = PH_REPLAY1;
                    end else begin
                        end_req  = 1'b1;
                        end_next = PH_DISCARD;
                    end
                end
                PH_DISCARD: begin
                    end_req  = 1'b1;
                    end_next = PH_DISCARD;
                end
                PH_BLK_HDR: begin
                    end_req = 1'b1;
                    if (b > 8'(PATTERN_LOG_MAX)) begin
                        raise_en   = 1'b1;
                        raise_code = srle_pkg::ERR_PATTERN_LONG;
                        end_next   = PH_DISCARD;
                    end else begin
                        n_log    = PL_W'(b);
                        end_next = PH_BLK_CNT;
                    end
                end
                PH_BLK_CNT: begin
                    n_run   = {8'd0, b};
                    n_fill  = '0;
                    end_req = 1'b1;
                    if (r_log == PL_W'(0)) begin
                        end_next = (b == 8'd0) ? PH_BLK_HDR : PH_LIT;
                    end else begin
                        end_next = PH_FILL;
                    end
                end
                PH_LIT: begin
                    do_emit  = 1'b1;
                    n_run    = r_run - 16'd1;
                    end_req  = 1'b1;
                    end_next = (n_run == 16'd0) ? PH_BLK_HDR : PH_LIT;
                end
                PH_FILL: begin
                    mem_we = 1'b1;
                    n_fill = r_fill + IDX_W'(1);
                    if (n_fill >= pat_len) begin
                        n_replay = '0;
                        if (r_run != 16'd0) begin
                            n_phase = PH_REPLAY2;
                        end else begin
                            end_req  = 1'b1;
                            end_next = PH_BLK_HDR;
                        end
                    end else begin
                        end_req  = 1'b1;
                        end_next = PH_FILL;
                    end
                end
                default: begin
                    n_payload = {8'd0, b};
                    n_count   = 16'd0;
                    n_err     = srle_pkg::ERR_NONE;
                    n_phase   = PH_LEN_HI;
                end
            endcase
        end

        if (end_req) begin
            if (n_payload == 16'd0) begin
                n_phase = PH_LEN_LO;
                done    = 1'b1;
            end else begin
                n_phase = end_next;
            end
        end

        if (do_emit) begin
            if (r_count < limit) begin
                out_ok   = 1'b1;
                out_data = emit_data;
            end else begin
                raise_en   = 1'b1;
                raise_code = srle_pkg::ERR_OVERFLOW;
            end
            if (r_count != 16'hFFFF) begin
                n_count = r_count + 16'd1;
            end
        end

        if (raise_en && r_err == srle_pkg::ERR_NONE) begin
            n_err = raise_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN_LO;
            r_payload <= '0;
            r_run     <= '0;
            r_log     <= '0;
            r_fill    <= '0;
            r_replay  <= '0;
            r_count   <= '0;
            r_err     <= srle_pkg::ERR_NONE;
        end else if (i_adv) begin
            r_phase   <= n_phase;
            r_payload <= n_payload;
            r_run     <= n_run;
            r_log     <= n_log;
            r_fill    <= n_fill;
            r_replay  <= n_replay;
            r_count   <= n_count;
            r_err     <= n_err;
        end
    end

    // The read port fetches the entry for the next replay step, with write data forwarded.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (mem_we) begin
                r_store[mem_waddr] <= mem_wdata;
            end
            if (mem_we && mem_waddr == mem_raddr) begin
                r_rd_data <= mem_wdata;
            end else begin
                r_rd_data <= r_store[mem_raddr];
            end
        end
    end

    always_comb begin
        o_result.out_valid      = out_ok;
        o_result.out_byte       = out_data;
        o_result.byte_taken     = taken;
        o_result.record_done    = done;
        o_result.decoded_length = n_count;
        o_result.error_code     = n_err;
    end

endmodule

`default_nettype wire

[rtl/core/sector_rle_expander.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sector record expander. Every input word (a slot that may or may not offer an
// encoded byte) yields exactly one output word, which carries at most one decoded
// byte, a flag telling whether the offered byte was consumed, the end-of-record
// mark, the running decoded length and the sticky error code of the record. While
// a pattern or byte pair is replayed the offered byte is not consumed, so the
// source must offer it again in a later word. Throughput is one word per clock in
// each direction while the output is not stalled: the whole decode step sits
// between the input register and the output register, and the pattern store is
// read one step ahead into a register. The sector size code may only be written
// while no word is in flight.

module sector_rle_expander #(
    parameter int PATTERN_LOG_MAX = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [srle_pkg::SIZE_CODE_W-1:0]  i_cfg_wr_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire srle_pkg::t_in_word                i_in_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output srle_pkg::t_out_word                    o_out_word
);

    logic                             r_in_valid;
    srle_pkg::t_in_word               r_in_word;
    logic                             r_out_valid;
    srle_pkg::t_out_word              r_out_word;
    logic [srle_pkg::SIZE_CODE_W-1:0] r_size_code;
    logic                             adv;
    srle_pkg::t_out_word              step_result;

    assign adv         = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !adv;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    srle_decoder #(
        .PATTERN_LOG_MAX(PATTERN_LOG_MAX)
    ) u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_item      (r_in_word),
        .i_size_code (r_size_code),
        .o_result    (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_code <= srle_pkg::SIZE_CODE_RESET;
        end else if (i_cfg_wr_en) begin
            r_size_code <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_word <= step_result;
        end
    end

endmodule

`default_nettype wire
